FILE: sv/cbf_pkg.sv
// Shared constants for the circular byte FIFO: store geometry, field widths,
// request and status codes. No dependencies.
package cbf_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_CHUNK = 64;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 11;
  localparam int CHUNK_W = $clog2(MAX_CHUNK + 1);
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLK_PUT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHUNK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ROLLBACK = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_DATA  = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

endpackage

FILE: sv/cbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/circular_byte_fifo.sv
// Top level of the circular byte FIFO: sequencer, ring pointers, result register.
// Depends on cbf_pkg and cbf_ram.
//
// Byte ring FIFO over a 1024 x 8 store whose used size is set by the
// buffer_size register (clamped to 1..DEPTH; a write also empties the ring
// and drops any open block). An input word is taken only while the sequencer
// is idle. Push, pop, block put, rollback, reset and unused codes are captured
// then executed and give one result word. A chunk get that succeeds gives its
// bytes, none past the ring's end, as result words, one byte per cycle while
// the result register takes them, through the store's single read port. The
// result register lets the next input word be captured while a result waits;
// execution stalls while it is full and not being drained. No clearing pass
// after reset: store entries are read only after they were written.
module circular_byte_fifo (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbf_pkg::REQ_W-1:0]   in_req_type,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_block_start,
  input  logic [cbf_pkg::CNT_W-1:0]   in_length,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cbf_pkg::STAT_W-1:0]  out_status,
  output logic [7:0]                  out_out_byte,
  output logic                        out_chunk_last,
  output logic [cbf_pkg::CNT_W-1:0]   out_fill_level,
  output logic [cbf_pkg::CNT_W-1:0]   out_free_space,
  output logic                        out_is_empty,
  output logic                        out_is_full,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbf_pkg::CNT_W-1:0]   cfg_buffer_size
);

  localparam int IDX_W = cbf_pkg::IDX_W;
  localparam int CNT_W = cbf_pkg::CNT_W;
  localparam int CHK_W = cbf_pkg::CHUNK_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CHUNK = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            bs_r, bs_nxt;
  logic [IDX_W-1:0]            ri_r, ri_nxt;
  logic [IDX_W-1:0]            wi_r, wi_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            blk_rem_r, blk_rem_nxt;
  logic                        drop_r, drop_nxt;
  logic [CHK_W-1:0]            cnt_r, cnt_nxt;

  // captured input word
  logic [cbf_pkg::REQ_W-1:0]   req_r;
  logic [7:0]                  byte_r;
  logic                        start_r;
  logic [CNT_W-1:0]            len_r;

  // result register
  logic                        out_valid_r;
  logic [cbf_pkg::STAT_W-1:0]  out_status_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic [CNT_W-1:0]            out_fill_r;
  logic [CNT_W-1:0]            out_free_r;
  logic                        out_empty_r;
  logic                        out_full_r;

  logic                        slot_free;
  logic                        in_acc;
  logic                        cfg_acc;
  logic                        ld;
  logic [cbf_pkg::STAT_W-1:0]  st;
  logic [7:0]                  ob;
  logic                        last;
  logic                        do_put;
  logic                        ring_full;
  logic [CNT_W-1:0]            need;
  logic [CNT_W-1:0]            room;
  logic [CNT_W-1:0]            cfg_clamped;
  logic [CNT_W-1:0]            wi_ext;

  logic                        ram_we;
  logic                        ram_re;
  logic [7:0]                  ram_rdata;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] bs);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(i) + CNT_W'(1);
    return (inc >= bs) ? '0 : IDX_W'(inc);
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign ring_full = (count_r >= bs_r);
  assign need      = (len_r == '0) ? CNT_W'(1) : len_r;
  assign room      = bs_r - CNT_W'(ri_r);
  assign wi_ext    = CNT_W'(wi_r);

  always_comb begin
    cfg_clamped = cfg_buffer_size;
    if (cfg_buffer_size == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_buffer_size > CNT_W'(cbf_pkg::DEPTH)) begin
      cfg_clamped = CNT_W'(cbf_pkg::DEPTH);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bs_nxt      = bs_r;
    ri_nxt      = ri_r;
    wi_nxt      = wi_r;
    count_nxt   = count_r;
    blk_rem_nxt = blk_rem_r;
    drop_nxt    = drop_r;
    cnt_nxt     = cnt_r;
    ld          = 1'b0;
    st          = cbf_pkg::ST_OK;
    ob          = '0;
    last        = 1'b1;
    do_put      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        ram_re = 1'b1;
        if (cfg_acc) begin
          bs_nxt      = cfg_clamped;
          ri_nxt      = '0;
          wi_nxt      = '0;
          count_nxt   = '0;
          blk_rem_nxt = '0;
          drop_nxt    = 1'b0;
        end else if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
          case (req_r)
            cbf_pkg::REQ_PUSH: begin
              do_put = 1'b1;
            end
            cbf_pkg::REQ_POP: begin
              if (count_r == '0) begin
                st = cbf_pkg::ST_NO_DATA;
              end else begin
                ob        = ram_rdata;
                ri_nxt    = next_idx(ri_r, bs_r);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            cbf_pkg::REQ_BLK_PUT: begin
              if (start_r) begin
                blk_rem_nxt = need - CNT_W'(1);
                if (bs_r - count_r < need) begin
                  // block does not fit: empty ring, drop the rest of the block
                  ri_nxt    = '0;
                  wi_nxt    = '0;
                  count_nxt = '0;
                  drop_nxt  = (need != CNT_W'(1));
                  st        = cbf_pkg::ST_NO_ROOM;
                end else begin
                  drop_nxt = 1'b0;
                  do_put   = 1'b1;
                end
              end else if (blk_rem_r != '0) begin
                blk_rem_nxt = blk_rem_r - CNT_W'(1);
                if (drop_r) begin
                  st = cbf_pkg::ST_NO_ROOM;
                end else begin
                  do_put = 1'b1;
                end
                if (blk_rem_r == CNT_W'(1)) begin
                  drop_nxt = 1'b0;
                end
              end else begin
                do_put = 1'b1;
              end
            end
            cbf_pkg::REQ_CHUNK: begin
              if (len_r > CNT_W'(cbf_pkg::MAX_CHUNK)) begin
                st = cbf_pkg::ST_TOO_LONG;
              end else if (count_r < len_r) begin
                st = cbf_pkg::ST_NO_DATA;
              end else if (len_r != '0) begin
                // first byte is already in the RAM read register
                ld        = 1'b0;
                state_nxt = S_CHUNK;
                cnt_nxt   = (len_r <= room) ? CHK_W'(len_r) : CHK_W'(room);
              end
            end
            cbf_pkg::REQ_ROLLBACK: begin
              if (len_r >= count_r) begin
                wi_nxt    = ri_r;
                count_nxt = '0;
              end else begin
                wi_nxt    = (wi_ext >= len_r) ? IDX_W'(wi_ext - len_r)
                                              : IDX_W'(wi_ext + bs_r - len_r);
                count_nxt = count_r - len_r;
              end
            end
            cbf_pkg::REQ_RESET: begin
              ri_nxt      = '0;
              wi_nxt      = '0;
              count_nxt   = '0;
              blk_rem_nxt = '0;
              drop_nxt    = 1'b0;
            end
            default: begin
            end
          endcase

          if (do_put) begin
            if (ring_full) begin
              st = cbf_pkg::ST_NO_ROOM;
            end else begin
              ram_we    = 1'b1;
              wi_nxt    = next_idx(wi_r, bs_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end

      S_CHUNK: begin
        if (slot_free) begin
          ld        = 1'b1;
          ram_re    = 1'b1;
          ob        = ram_rdata;
          ri_nxt    = next_idx(ri_r, bs_r);
          count_nxt = count_r - CNT_W'(1);
          cnt_nxt   = cnt_r - CHK_W'(1);
          last      = (cnt_r == CHK_W'(1));
          if (last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  cbf_ram #(
    .WIDTH (8),
    .DEPTH (cbf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (ri_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bs_r        <= CNT_W'(cbf_pkg::DEPTH);
      ri_r        <= '0;
      wi_r        <= '0;
      count_r     <= '0;
      blk_rem_r   <= '0;
      drop_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bs_r        <= bs_nxt;
      ri_r        <= ri_nxt;
      wi_r        <= wi_nxt;
      count_r     <= count_nxt;
      blk_rem_r   <= blk_rem_nxt;
      drop_r      <= drop_nxt;
      cnt_r       <= cnt_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_req_type;
      byte_r  <= in_data_byte;
      start_r <= in_block_start;
      len_r   <= in_length;
    end
    if (ld) begin
      out_status_r <= st;
      out_byte_r   <= ob;
      out_last_r   <= last;
      out_fill_r   <= count_nxt;
      out_free_r   <= bs_r - count_nxt;
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == bs_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_out_byte   = out_byte_r;
  assign out_chunk_last = out_last_r;
  assign out_fill_level = out_fill_r;
  assign out_free_space = out_free_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

endmodule
